// ----- rtl/fipp_pkg.sv -----
// Shared types and constants of the flash image page packer.
// Depends on nothing; every other file of the block imports it.
package fipp_pkg;

	localparam int PAGE_BYTES_DEF  = 64;
	localparam int FRAME_BYTES_DEF = 8;
	localparam int ROW_BYTES_DEF   = 256;

	// Upper ends of the parameter ranges; they size the command fields.
	localparam int PAGE_BYTES_MAX  = 256;
	localparam int FRAME_BYTES_MAX = 64;

	localparam int PAYLOAD_COUNT   = 6;
	localparam int ADDR_W          = 24;
	localparam int CFG_IDX_W       = 2;
	localparam int CMD_FIFO_DEPTH  = 2;

	localparam int LEN_W = $clog2(PAGE_BYTES_MAX + 1);
	localparam int PTR_W = $clog2(PAGE_BYTES_MAX + FRAME_BYTES_MAX);

	localparam logic [ADDR_W-1:0] IMAGE_LENGTH_RST = 24'h000000;
	localparam logic [ADDR_W-1:0] IMAGE_BASE_RST   = 24'h002000;
	localparam logic [ADDR_W-1:0] RECORD_ADDR_RST  = 24'h001000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_LENGTH = 2'd0,
		CFG_IMAGE_BASE   = 2'd1,
		CFG_RECORD_ADDR  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_ERASE = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_NONE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_BLOCK  = 2'd1,
		CMD_QUIET  = 2'd2
	} cmd_kind_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_EVAL,
		F_WRITE,
		F_PUSH_REC,
		F_PUSH_BLK,
		F_PUSH_QUIET
	} front_st_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_QUIET,
		B_ERASE,
		B_FILL,
		B_BEAT
	} back_st_t;

	typedef struct packed {
		logic       func;
		logic [7:0] payload_byte_0;
		logic [7:0] payload_byte_1;
		logic [7:0] payload_byte_2;
		logic [7:0] payload_byte_3;
		logic [7:0] payload_byte_4;
		logic [7:0] payload_byte_5;
		logic [7:0] status_code;
	} frame_t;

	typedef struct packed {
		action_t           action;
		logic [ADDR_W-1:0] flash_address;
		logic [63:0]       write_data;
		logic [3:0]        byte_count;
		logic              last;
		logic              session_done;
	} flash_t;

	// One unit of back-end work: a record page, a ring block or a quiet result.
	typedef struct packed {
		cmd_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [PTR_W-1:0]  start;
		logic [7:0]        first;
		logic              last;
		logic              done;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		logic [7:0]       data;
	} ring_wr_t;

endpackage

// ----- rtl/fipp_cmd_fifo.sv -----
// Short command queue between the front and back ends of the page packer.
// Depends on fipp_pkg for the command type.
module fipp_cmd_fifo import fipp_pkg::*; #(
	parameter int DEPTH = CMD_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output logic avail,
	output cmd_t rd_cmd
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = count_q == CW'(DEPTH);
	assign avail  = count_q != '0;
	assign rd_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("command queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail)
		else $error("command queue read while empty");

endmodule

// ----- rtl/fipp_front.sv -----
// Front end of the page packer: accepts frames, keeps session and ring
// bookkeeping, writes payload into the ring and queues commands. Uses fipp_pkg.
module fipp_front import fipp_pkg::*; #(
	parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	output logic                 frame_ready,
	input  frame_t               frame,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	output logic                 push,
	output cmd_t                 push_cmd,
	input  logic                 full,
	output ring_wr_t             ring_wr,
	input  logic                 blk_read_done
);

	localparam int RING  = PAGE_BYTES + FRAME_BYTES;
	localparam int RP_W  = $clog2(RING);
	localparam int CNT_W = $clog2(RING + 1);
	localparam int BLK_W = $clog2(PAGE_BYTES + 1);

	front_st_t st_q, st_d;

	logic [ADDR_W-1:0] image_length_q;
	logic [ADDR_W-1:0] image_base_q;
	logic [ADDR_W-1:0] record_addr_q;

	frame_t            item_q;
	logic              in_session_q;
	logic [ADDR_W-1:0] rem_q;
	logic [ADDR_W-1:0] addr_q;
	logic [RP_W-1:0]   head_q;
	logic [RP_W-1:0]   tail_q;
	logic              rec_q;
	logic              prog_q;
	logic              done_q;
	logic [BLK_W-1:0]  blk_q;
	logic [ADDR_W-1:0] blk_addr_q;
	logic [RP_W-1:0]   blk_start_q;
	logic [RP_W-1:0]   wr_ptr_q;
	logic [2:0]        wr_idx_q;
	logic              pending_q;

	logic [7:0]        pay [PAYLOAD_COUNT];
	logic              accept;
	logic              eval_go;
	logic              rem_zero;
	logic [BLK_W-1:0]  blk;
	logic [CNT_W-1:0]  valid_cnt;
	logic [CNT_W-1:0]  valid_after;
	logic              do_store;
	logic              do_prog;
	logic              do_done;
	logic [RP_W:0]     tail_sum;
	logic [RP_W:0]     head_sum;
	logic [RP_W-1:0]   tail_new;
	logic [RP_W-1:0]   tail_eff;
	logic [RP_W-1:0]   head_new;
	logic [ADDR_W-1:0] rem_after;
	logic              write_end;
	front_st_t         after_st;

	function automatic logic [CNT_W-1:0] ring_count(input logic [RP_W-1:0] t,
		input logic [RP_W-1:0] h);
		logic [CNT_W-1:0] r;
		if (t >= h) begin
			r = CNT_W'(t) - CNT_W'(h);
		end else begin
			r = CNT_W'(t) + CNT_W'(RING) - CNT_W'(h);
		end
		return r;
	endfunction

	assign pay[0] = item_q.payload_byte_0;
	assign pay[1] = item_q.payload_byte_1;
	assign pay[2] = item_q.payload_byte_2;
	assign pay[3] = item_q.payload_byte_3;
	assign pay[4] = item_q.payload_byte_4;
	assign pay[5] = item_q.payload_byte_5;

	assign frame_ready = st_q == F_IDLE;
	assign accept      = frame_valid && frame_ready;
	// Hold ring updates until the back end has copied out the previous block.
	assign eval_go     = st_q == F_EVAL && !pending_q;

	always_comb begin
		rem_zero    = rem_q == '0;
		blk         = (rem_q < ADDR_W'(PAGE_BYTES)) ? BLK_W'(rem_q) : BLK_W'(PAGE_BYTES);
		valid_cnt   = ring_count(tail_q, head_q);
		do_store    = !rem_zero &&
			(CNT_W'(RING) - valid_cnt) >= CNT_W'(PAYLOAD_COUNT);
		tail_sum    = {1'b0, tail_q} + (RP_W + 1)'(PAYLOAD_COUNT);
		tail_new    = (tail_sum >= (RP_W + 1)'(RING)) ?
			RP_W'(tail_sum - (RP_W + 1)'(RING)) : RP_W'(tail_sum);
		tail_eff    = do_store ? tail_new : tail_q;
		valid_after = ring_count(tail_eff, head_q);
		do_prog     = !rem_zero && valid_after >= CNT_W'(blk);
		head_sum    = {1'b0, head_q} + (RP_W + 1)'(blk);
		head_new    = (head_sum >= (RP_W + 1)'(RING)) ?
			RP_W'(head_sum - (RP_W + 1)'(RING)) : RP_W'(head_sum);
		rem_after   = rem_q - ADDR_W'(blk);
		do_done     = rem_zero || (do_prog && rem_after == '0);
		write_end   = wr_idx_q == 3'(PAYLOAD_COUNT - 1);
	end

	always_comb begin
		st_d     = st_q;
		push     = 1'b0;
		push_cmd = '0;
		ring_wr  = '0;
		after_st = rec_q ? F_PUSH_REC : (prog_q ? F_PUSH_BLK : F_PUSH_QUIET);
		case (st_q)
			F_IDLE: begin
				if (accept) begin
					st_d = frame.func ? F_PUSH_REC : F_EVAL;
				end
			end
			F_EVAL: begin
				if (eval_go) begin
					if (do_store) begin
						st_d = F_WRITE;
					end else if (rec_q) begin
						st_d = F_PUSH_REC;
					end else begin
						st_d = do_prog ? F_PUSH_BLK : F_PUSH_QUIET;
					end
				end
			end
			F_WRITE: begin
				ring_wr.en   = 1'b1;
				ring_wr.addr = PTR_W'(wr_ptr_q);
				ring_wr.data = pay[wr_idx_q];
				if (write_end) begin
					st_d = after_st;
				end
			end
			F_PUSH_REC: begin
				push_cmd.kind  = CMD_RECORD;
				push_cmd.addr  = record_addr_q;
				push_cmd.len   = LEN_W'(PAGE_BYTES);
				push_cmd.first = item_q.func ? item_q.status_code : 8'h00;
				push_cmd.last  = item_q.func || !prog_q;
				push_cmd.done  = !item_q.func && !prog_q && done_q;
				if (!full) begin
					push = 1'b1;
					st_d = (!item_q.func && prog_q) ? F_PUSH_BLK : F_IDLE;
				end
			end
			F_PUSH_BLK: begin
				push_cmd.kind  = CMD_BLOCK;
				push_cmd.addr  = blk_addr_q;
				push_cmd.len   = LEN_W'(blk_q);
				push_cmd.start = PTR_W'(blk_start_q);
				push_cmd.last  = 1'b1;
				push_cmd.done  = done_q;
				if (!full) begin
					push = 1'b1;
					st_d = F_IDLE;
				end
			end
			F_PUSH_QUIET: begin
				push_cmd.kind = CMD_QUIET;
				push_cmd.last = 1'b1;
				push_cmd.done = done_q;
				if (!full) begin
					push = 1'b1;
					st_d = F_IDLE;
				end
			end
			default: begin
				st_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= IMAGE_LENGTH_RST;
			image_base_q   <= IMAGE_BASE_RST;
			record_addr_q  <= RECORD_ADDR_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IMAGE_LENGTH) begin
				image_length_q <= cfg_wdata;
			end else if (cfg_index == CFG_IMAGE_BASE) begin
				image_base_q <= cfg_wdata;
			end else if (cfg_index == CFG_RECORD_ADDR) begin
				record_addr_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_session_q <= 1'b0;
			rem_q        <= '0;
			addr_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			rec_q        <= 1'b0;
			prog_q       <= 1'b0;
			done_q       <= 1'b0;
			pending_q    <= 1'b0;
			wr_ptr_q     <= '0;
			wr_idx_q     <= '0;
		end else begin
			if (accept && !frame.func) begin
				rec_q <= !in_session_q;
				// Start a session: load length and base, empty the ring.
				if (!in_session_q) begin
					rem_q        <= image_length_q;
					addr_q       <= image_base_q;
					head_q       <= '0;
					tail_q       <= '0;
					in_session_q <= 1'b1;
				end
			end
			if (eval_go) begin
				prog_q   <= do_prog;
				done_q   <= do_done;
				tail_q   <= tail_eff;
				wr_ptr_q <= tail_q;
				wr_idx_q <= '0;
				if (do_prog) begin
					head_q <= head_new;
					addr_q <= addr_q + ADDR_W'(blk);
					rem_q  <= rem_after;
				end
				if (do_done) begin
					in_session_q <= 1'b0;
				end
			end
			if (st_q == F_WRITE) begin
				wr_ptr_q <= (wr_ptr_q == RP_W'(RING - 1)) ? '0 : wr_ptr_q + 1'b1;
				wr_idx_q <= wr_idx_q + 1'b1;
			end
			if (st_q == F_PUSH_BLK && !full) begin
				pending_q <= 1'b1;
			end else if (blk_read_done) begin
				pending_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= frame;
		end
		if (eval_go) begin
			blk_q       <= blk;
			blk_addr_q  <= addr_q;
			blk_start_q <= head_q;
		end
	end

	a_no_write_while_read: assert property (@(posedge clk) disable iff (!arst_n)
		ring_wr.en |-> !pending_q)
		else $error("ring written while a block is still being read");

	a_read_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		blk_read_done |-> pending_q)
		else $error("block read finished with no block outstanding");

endmodule

// ----- rtl/fipp_back.sv -----
// Back end of the page packer: owns the payload ring, turns queued commands into erase,
// write-beat and quiet transactions through an output register. Uses fipp_pkg.
module fipp_back import fipp_pkg::*; #(
	parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int ROW_BYTES   = ROW_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_avail,
	input  cmd_t     cmd,
	output logic     cmd_pop,
	input  ring_wr_t ring_wr,
	output logic     blk_read_done,
	output logic     flash_valid,
	input  logic     flash_ready,
	output flash_t   flash
);

	localparam int RING  = PAGE_BYTES + FRAME_BYTES;
	localparam int RP_W  = $clog2(RING);
	localparam int BLK_W = $clog2(PAGE_BYTES + 1);
	localparam logic [ADDR_W-1:0] ROW_MASK = ADDR_W'(ROW_BYTES - 1);

	back_st_t st_q, st_d;

	logic [7:0]        ring_mem [RING];
	logic [7:0]        rdata_s1;
	logic              rv_s1;
	logic [2:0]        ridx_s1;

	cmd_t              cur_q;
	logic [BLK_W-1:0]  off_q;
	logic [RP_W-1:0]   rd_ptr_q;
	logic [3:0]        iss_q;
	logic [3:0]        rcv_q;
	logic [7:0][7:0]   beat_q;
	logic              out_valid_q;
	flash_t            out_q;

	logic              out_free;
	logic              load_out;
	flash_t            out_d;
	logic [BLK_W-1:0]  beat_rem;
	logic [3:0]        beat_cnt;
	logic              final_beat;
	logic              issue;
	logic              fill_start;
	logic              fill_end;
	logic [63:0]       beat_data;

	assign out_free    = !out_valid_q || flash_ready;
	assign flash_valid = out_valid_q;
	assign flash       = out_q;

	always_comb begin
		beat_rem   = cur_q.len[BLK_W-1:0] - off_q;
		beat_cnt   = (beat_rem > BLK_W'(8)) ? 4'd8 : 4'(beat_rem);
		final_beat = beat_rem <= BLK_W'(8);
		issue      = st_q == B_FILL && iss_q < beat_cnt;
		fill_end   = st_q == B_FILL && rcv_q == beat_cnt;
		if (cur_q.kind == CMD_BLOCK) begin
			beat_data = beat_q;
		end else begin
			beat_data = (off_q == '0) ? 64'(cur_q.first) : 64'h0;
		end
	end

	assign blk_read_done = fill_end && final_beat;

	always_comb begin
		st_d       = st_q;
		cmd_pop    = 1'b0;
		load_out   = 1'b0;
		fill_start = 1'b0;
		out_d      = '0;
		out_d.action = ACT_NONE;
		case (st_q)
			B_IDLE: begin
				if (cmd_avail) begin
					cmd_pop = 1'b1;
					if (cmd.kind == CMD_QUIET) begin
						st_d = B_QUIET;
					end else if ((cmd.addr & ROW_MASK) == '0) begin
						st_d = B_ERASE;
					end else if (cmd.kind == CMD_BLOCK) begin
						st_d       = B_FILL;
						fill_start = 1'b1;
					end else begin
						st_d = B_BEAT;
					end
				end
			end
			B_QUIET: begin
				out_d.last         = cur_q.last;
				out_d.session_done = cur_q.done;
				if (out_free) begin
					load_out = 1'b1;
					st_d     = B_IDLE;
				end
			end
			B_ERASE: begin
				out_d.action        = ACT_ERASE;
				out_d.flash_address = cur_q.addr;
				if (out_free) begin
					load_out = 1'b1;
					if (cur_q.kind == CMD_BLOCK) begin
						st_d       = B_FILL;
						fill_start = 1'b1;
					end else begin
						st_d = B_BEAT;
					end
				end
			end
			B_FILL: begin
				if (fill_end) begin
					st_d = B_BEAT;
				end
			end
			B_BEAT: begin
				out_d.action        = ACT_WRITE;
				out_d.flash_address = cur_q.addr + ADDR_W'(off_q);
				out_d.write_data    = beat_data;
				out_d.byte_count    = beat_cnt;
				out_d.last          = final_beat && cur_q.last;
				out_d.session_done  = final_beat && cur_q.done;
				if (out_free) begin
					load_out = 1'b1;
					if (final_beat) begin
						st_d = B_IDLE;
					end else if (cur_q.kind == CMD_BLOCK) begin
						st_d       = B_FILL;
						fill_start = 1'b1;
					end
				end
			end
			default: begin
				st_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_wr.en) begin
			ring_mem[ring_wr.addr[RP_W-1:0]] <= ring_wr.data;
		end
		rdata_s1 <= ring_mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rv_s1       <= 1'b0;
			iss_q       <= '0;
			rcv_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (flash_ready) begin
				out_valid_q <= 1'b0;
			end
			rv_s1 <= issue;
			if (fill_start) begin
				iss_q <= '0;
				rcv_q <= '0;
			end else begin
				if (issue) begin
					iss_q <= iss_q + 1'b1;
				end
				if (rv_s1) begin
					rcv_q <= rcv_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
		if (cmd_pop) begin
			cur_q    <= cmd;
			off_q    <= '0;
			rd_ptr_q <= cmd.start[RP_W-1:0];
		end else if (issue) begin
			// Advance through the ring one byte per cycle.
			rd_ptr_q <= (rd_ptr_q == RP_W'(RING - 1)) ? '0 : rd_ptr_q + 1'b1;
		end
		if (issue) begin
			ridx_s1 <= iss_q[2:0];
		end
		if (fill_start) begin
			beat_q <= '0;
		end else if (rv_s1) begin
			beat_q[ridx_s1] <= rdata_s1;
		end
		if (st_q == B_BEAT && out_free && !final_beat) begin
			off_q <= off_q + BLK_W'(8);
		end
	end

	a_erase_fields: assert property (@(posedge clk) disable iff (!arst_n)
		flash_valid && flash.action == ACT_ERASE |->
			flash.byte_count == 4'd0 && flash.write_data == 64'h0 && !flash.last)
		else $error("erase transaction carries data or ends the item");

	a_beat_count: assert property (@(posedge clk) disable iff (!arst_n)
		flash_valid && flash.action == ACT_WRITE |->
			flash.byte_count != 4'd0 && flash.byte_count <= 4'd8)
		else $error("write beat byte count out of range");

	a_read_done_block: assert property (@(posedge clk) disable iff (!arst_n)
		blk_read_done |-> cur_q.kind == CMD_BLOCK && !rv_s1)
		else $error("ring read finished outside a block or with a read in flight");

endmodule

// ----- rtl/flash_image_page_packer.sv -----
// Flash image page packer: takes download frames and finish items, and issues row
// erase transactions, write transactions of up to eight bytes and quiet results.
// Each transaction leaves through an output register, so the frame side keeps
// working while a result waits. The front end takes a data frame through acceptance,
// bookkeeping, six single-byte writes into the payload ring and a queue push, and a
// finish item through acceptance and a queue push. The back end, behind a two-entry
// command queue, issues one transaction a cycle, while the receiver takes them, for a
// status record page (one erase when the record address is row aligned, then
// PAGE_BYTES/8 beats); for an image block each beat first reads its bytes from the
// byte-wide ring. A frame that follows a block waits until that block has been read
// out of the ring. There is no clearing pass after reset.
// Depends on fipp_pkg, fipp_front, fipp_cmd_fifo and fipp_back.
module flash_image_page_packer import fipp_pkg::*; #(
	parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int ROW_BYTES   = ROW_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	output logic                 frame_ready,
	input  frame_t               frame,
	output logic                 flash_valid,
	input  logic                 flash_ready,
	output flash_t               flash,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata
);

	logic     push;
	cmd_t     push_cmd;
	logic     full;
	logic     pop;
	logic     avail;
	cmd_t     rd_cmd;
	ring_wr_t ring_wr;
	logic     blk_read_done;

	fipp_front #(
		.PAGE_BYTES (PAGE_BYTES),
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.push         (push),
		.push_cmd     (push_cmd),
		.full         (full),
		.ring_wr      (ring_wr),
		.blk_read_done(blk_read_done)
	);

	fipp_cmd_fifo #(
		.DEPTH(CMD_FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(push_cmd),
		.full  (full),
		.pop   (pop),
		.avail (avail),
		.rd_cmd(rd_cmd)
	);

	fipp_back #(
		.PAGE_BYTES (PAGE_BYTES),
		.FRAME_BYTES(FRAME_BYTES),
		.ROW_BYTES  (ROW_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_avail    (avail),
		.cmd          (rd_cmd),
		.cmd_pop      (pop),
		.ring_wr      (ring_wr),
		.blk_read_done(blk_read_done),
		.flash_valid  (flash_valid),
		.flash_ready  (flash_ready),
		.flash        (flash)
	);

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Testbench of flash_image_page_packer: sends download frames and finish items,
// predicts every flash command and checks each one as it leaves the block.
// Depends on fipp_pkg and the flash_image_page_packer RTL.
module testbench;
	import fipp_pkg::*;

	localparam int RING_BYTES     = PAGE_BYTES_DEF + FRAME_BYTES_DEF;
	localparam int RUN_LIMIT      = 1000000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int REPORT_LIMIT   = 10;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 frame_valid = 1'b0;
	logic                 frame_ready;
	frame_t               frame       = '0;
	logic                 flash_valid;
	logic                 flash_ready = 1'b0;
	flash_t               flash;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [ADDR_W-1:0]    cfg_wdata   = '0;

	flash_image_page_packer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.flash_valid (flash_valid),
		.flash_ready (flash_ready),
		.flash       (flash),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Register mirror and packer state.
	logic [ADDR_W-1:0] reg_length = IMAGE_LENGTH_RST;
	logic [ADDR_W-1:0] reg_base   = IMAGE_BASE_RST;
	logic [ADDR_W-1:0] reg_record = RECORD_ADDR_RST;
	bit                sess_open  = 1'b0;
	logic [ADDR_W-1:0] len_left   = '0;
	logic [ADDR_W-1:0] next_addr  = '0;
	logic [7:0]        ring_bytes [RING_BYTES];
	int                ring_rd    = 0;
	int                ring_wr    = 0;
	logic [7:0]        page_buf   [PAGE_BYTES_DEF];

	flash_t      flash_cmds_due [$];
	frame_t      frames_to_send [$];
	int unsigned frames_queued   = 0;
	int unsigned frames_offered  = 0;
	int unsigned frames_accepted = 0;
	int unsigned cmd_mismatches  = 0;

	int unsigned tx_idle_pct    = 0;
	int unsigned rx_idle_pct    = 0;
	int unsigned rx_holds_asked = 0;
	int unsigned rx_holds_taken = 0;
	int unsigned rx_hold_left   = 0;

	function automatic int ring_fill();
		return (ring_wr >= ring_rd) ? ring_wr - ring_rd : ring_wr + RING_BYTES - ring_rd;
	endfunction

	function automatic void add_cmd(action_t act, logic [ADDR_W-1:0] addr,
			logic [63:0] data, logic [3:0] cnt);
		flash_t c;
		c.action        = act;
		c.flash_address = addr;
		c.write_data    = data;
		c.byte_count    = cnt;
		c.last          = 1'b0;
		c.session_done  = 1'b0;
		flash_cmds_due.push_back(c);
	endfunction

	// Program len bytes of page_buf: erase on a row boundary, then beats of up to 8.
	function automatic void program_block(logic [ADDR_W-1:0] addr, int len);
		logic [63:0] data;
		int          cnt;
		int          off;
		int          k;
		if (addr % ROW_BYTES_DEF == 0)
			add_cmd(ACT_ERASE, addr, '0, '0);
		for (off = 0; off < len; off += 8) begin
			cnt  = (len - off > 8) ? 8 : len - off;
			data = '0;
			for (k = 0; k < cnt; k++)
				data[8*k +: 8] = page_buf[off + k];
			add_cmd(ACT_WRITE, addr + ADDR_W'(off), data, 4'(cnt));
		end
	endfunction

	function automatic void write_record(logic [7:0] first);
		int i;
		for (i = 0; i < PAGE_BYTES_DEF; i++)
			page_buf[i] = 8'h00;
		page_buf[0] = first;
		program_block(reg_record, PAGE_BYTES_DEF);
	endfunction

	function automatic void predict_flash_cmds(frame_t f);
		logic [7:0] payload [PAYLOAD_COUNT];
		flash_t     tail;
		bit         done;
		int         due_base;
		int         blk;
		int         i;
		done     = 1'b0;
		due_base = flash_cmds_due.size();
		payload  = '{f.payload_byte_0, f.payload_byte_1, f.payload_byte_2,
			f.payload_byte_3, f.payload_byte_4, f.payload_byte_5};
		if (f.func) begin
			write_record(f.status_code);
		end else begin
			if (!sess_open) begin
				len_left  = reg_length;
				next_addr = reg_base;
				ring_rd   = 0;
				ring_wr   = 0;
				sess_open = 1'b1;
				write_record(8'h00);
			end
			if (len_left != 0) begin
				blk = (len_left < PAGE_BYTES_DEF) ? int'(len_left) : PAGE_BYTES_DEF;
				if (RING_BYTES - ring_fill() >= PAYLOAD_COUNT) begin
					for (i = 0; i < PAYLOAD_COUNT; i++) begin
						ring_bytes[ring_wr] = payload[i];
						ring_wr = (ring_wr + 1 >= RING_BYTES) ? 0 : ring_wr + 1;
					end
				end
				if (ring_fill() >= blk) begin
					for (i = 0; i < blk; i++) begin
						page_buf[i] = ring_bytes[ring_rd];
						ring_rd = (ring_rd + 1 >= RING_BYTES) ? 0 : ring_rd + 1;
					end
					program_block(next_addr, blk);
					next_addr = next_addr + ADDR_W'(blk);
					len_left  = len_left - ADDR_W'(blk);
					if (len_left == 0) begin
						sess_open = 1'b0;
						done      = 1'b1;
					end
				end
			end else begin
				sess_open = 1'b0;
				done      = 1'b1;
			end
		end
		if (flash_cmds_due.size() == due_base)
			add_cmd(ACT_NONE, '0, '0, '0);
		tail = flash_cmds_due.pop_back();
		tail.last         = 1'b1;
		tail.session_done = done;
		flash_cmds_due.push_back(tail);
	endfunction

	function automatic void report_mismatch(string what, flash_t got, flash_t want);
		cmd_mismatches++;
		if (cmd_mismatches <= REPORT_LIMIT)
			$display("%0t %s: got %0d/%h/%h/%0d/%b/%b want %0d/%h/%h/%0d/%b/%b", $time, what,
				got.action, got.flash_address, got.write_data, got.byte_count, got.last,
				got.session_done, want.action, want.flash_address, want.write_data,
				want.byte_count, want.last, want.session_done);
	endfunction

	function automatic void check_flash(flash_t got);
		flash_t want;
		if (flash_cmds_due.size() == 0) begin
			report_mismatch("unexpected flash transaction", got, '0);
			return;
		end
		want = flash_cmds_due.pop_front();
		if (got.action !== want.action || got.flash_address !== want.flash_address ||
				got.write_data !== want.write_data || got.byte_count !== want.byte_count ||
				got.last !== want.last || got.session_done !== want.session_done)
			report_mismatch("flash transaction mismatch", got, want);
	endfunction

	// Predict on frame acceptance before checking, so same-edge results find their entry.
	always @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			predict_flash_cmds(frame);
			frames_accepted++;
		end
		if (flash_valid && flash_ready)
			check_flash(flash);
	end

	// Hold valid and payload until the transaction completes.
	always @(negedge clk) begin
		if (frames_offered == frames_accepted) begin
			if (frames_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				frame       <= frames_to_send.pop_front();
				frame_valid <= 1'b1;
				frames_offered++;
			end else begin
				frame_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_holds_taken != rx_holds_asked) begin
			rx_holds_taken = rx_holds_asked;
			rx_hold_left   = RX_HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			flash_ready <= 1'b0;
		end else begin
			flash_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send(input frame_t f);
		int unsigned ticket;
		frames_to_send.push_back(f);
		frames_queued++;
		ticket = frames_queued;
		wait (frames_accepted >= ticket);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (flash_cmds_due.size() != 0 || frames_accepted != frames_queued);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_config(input logic [ADDR_W-1:0] length, base, record);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IMAGE_LENGTH;
		cfg_wdata <= length;
		@(negedge clk);
		cfg_index <= CFG_IMAGE_BASE;
		cfg_wdata <= base;
		@(negedge clk);
		cfg_index <= CFG_RECORD_ADDR;
		cfg_wdata <= record;
		@(negedge clk);
		cfg_we     <= 1'b0;
		reg_length = length;
		reg_base   = base;
		reg_record = record;
	endtask

	function automatic frame_t make_frame(logic func, logic [47:0] bytes, logic [7:0] status);
		frame_t f;
		f.func = func;
		{f.payload_byte_5, f.payload_byte_4, f.payload_byte_3,
			f.payload_byte_2, f.payload_byte_1, f.payload_byte_0} = bytes;
		f.status_code = status;
		return f;
	endfunction

	function automatic frame_t random_frame(logic func);
		return make_frame(func, 48'({$urandom, $urandom}), 8'($urandom));
	endfunction

	// Finish items and a zero-length session under the reset configuration.
	task automatic test_reset_config();
		send(make_frame(1'b1, 48'h0, 8'hFF));
		send(make_frame(1'b0, 48'hFFFF_FFFF_FFFF, 8'h00));
		send(make_frame(1'b1, 48'hFFFF_FFFF_FFFF, 8'h00));
		wait_idle();
	endtask

	// Short image near the top of the address space: record wraps, quiet frame,
	// then a partial block whose second beat wraps to address zero.
	task automatic test_short_session();
		write_config(24'd13, 24'hFFFFF8, 24'hFFFFC1);
		send(make_frame(1'b0, 48'h0, 8'hFF));
		send(make_frame(1'b1, 48'h0, 8'hA5));
		send(make_frame(1'b0, 48'hFFFF_FFFF_FFFF, 8'h00));
		send(make_frame(1'b0, 48'h55AA_55AA_55AA, 8'h5A));
		wait_idle();
	endtask

	task automatic test_full_page();
		int          i;
		logic [47:0] bytes;
		write_config(24'd64, 24'h000000, 24'hFFFFFF);
		for (i = 0; i < 11; i++) begin
			bytes = {8'(6*i+5), 8'(6*i+4), 8'(6*i+3), 8'(6*i+2), 8'(6*i+1), 8'(6*i)};
			send(make_frame(1'b0, bytes, 8'(i)));
		end
		wait_idle();
	endtask

	// One frame opens and closes the session: record plus block in one item.
	task automatic test_single_frame_sessions();
		write_config(24'd6, 24'hFFFFFF, 24'h000000);
		send(make_frame(1'b0, 48'h0123_4567_89AB, 8'h3C));
		wait_idle();
		write_config(24'd5, 24'h000300, 24'h000000);
		send(make_frame(1'b0, 48'hFEDC_BA98_7654, 8'hC3));
		wait_idle();
	endtask

	task automatic test_random_sessions(input int unsigned n_items);
		int unsigned       sent;
		int unsigned       pick;
		bit                began;
		frame_t            f;
		logic [ADDR_W-1:0] length;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] record;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 30)
				length = 24'($urandom_range(0, 12));
			else if (pick < 70)
				length = 24'($urandom_range(13, 200));
			else if (pick < 90)
				length = 24'(64 * $urandom_range(1, 4));
			else
				length = 24'($urandom_range(201, 400));
			pick = $urandom_range(99);
			if (pick < 25)
				base = 24'($urandom_range(0, 16'hFFFF) << 8);
			else if (pick < 40)
				base = 24'hFFFFFF - 24'($urandom_range(0, 300));
			else
				base = 24'($urandom);
			pick = $urandom_range(99);
			if (pick < 30)
				record = 24'($urandom_range(0, 16'hFFFF) << 8);
			else if (pick < 40)
				record = 24'hFFFFFF - 24'($urandom_range(0, 80));
			else
				record = 24'($urandom);
			write_config(length, base, record);
			began = 1'b0;
			do begin
				f = random_frame($urandom_range(9) == 0);
				if (!f.func)
					began = 1'b1;
				send(f);
				sent++;
			end while (!began || sess_open);
			if ($urandom_range(3) == 0) begin
				send(random_frame(1'b1));
				sent++;
			end
			wait_idle();
		end
	endtask

	// Hold the receiver off while frames keep coming, so the input side stalls.
	task automatic test_backpressure();
		write_config(24'd128, 24'h000400, 24'h000800);
		rx_holds_asked++;
		do send(random_frame(1'b0));
		while (sess_open);
		wait_idle();
	endtask

	// Longest image: the session stays open, blocks cross the top of the address space.
	task automatic test_max_length();
		int i;
		write_config(24'hFFFFFF, 24'hFFFFC0, 24'hFFFFFF);
		for (i = 0; i < 24; i++)
			send(random_frame(i == 12));
		wait_idle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 23;
		rx_idle_pct = 62;
		test_reset_config();
		test_short_session();
		test_full_page();
		test_single_frame_sessions();
		test_random_sessions(100);

		tx_idle_pct = 62;
		rx_idle_pct = 23;
		test_random_sessions(100);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_sessions(100);
		test_backpressure();
		test_max_length();

		wait_idle();
		if (cmd_mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/fipp_pkg.sv
rtl/fipp_cmd_fifo.sv
rtl/fipp_front.sv
rtl/fipp_back.sv
rtl/flash_image_page_packer.sv
sim/testbench.sv
